// ----- design/gsp_pkg.sv -----
package gsp_pkg;

    // Defaults for the top-level parameters
    localparam int STACK_DEPTH_DEF = 1024;
    localparam int QUBIT_BITS_DEF  = 8;

    // Fixed field widths
    localparam int GATE_W = 2;
    localparam int ROT_W  = 32;

    // Gate encoding, same as on the ports
    typedef enum logic [GATE_W-1:0] {
        GATE_H    = 2'd0,
        GATE_RZ   = 2'd1,
        GATE_CNOT = 2'd2,
        GATE_SWAP = 2'd3
    } t_gate;

    // Item action codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Outcome of a push against the current top entry (one-hot)
    typedef struct packed {
        logic pop;
        logic merge;
        logic push;
        logic drop;
    } t_rule;

endpackage

// ----- design/gsp_ram.sv -----
module gsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/gsp_rules.sv -----
module gsp_rules #(
    parameter int QUBIT_BITS = 8
) (
    input  logic [gsp_pkg::GATE_W-1:0]       i_gate,
    input  logic [QUBIT_BITS-1:0]            i_qa,
    input  logic [QUBIT_BITS-1:0]            i_qb,
    input  logic signed [gsp_pkg::ROT_W-1:0] i_rot,
    input  logic                             i_top_valid,
    input  logic [gsp_pkg::GATE_W-1:0]       i_top_gate,
    input  logic [QUBIT_BITS-1:0]            i_top_qa,
    input  logic [QUBIT_BITS-1:0]            i_top_qb,
    input  logic signed [gsp_pkg::ROT_W-1:0] i_top_rot,
    input  logic                             i_full,
    output gsp_pkg::t_rule                   o_rule,
    output logic signed [gsp_pkg::ROT_W-1:0] o_merged_rot
);

    import gsp_pkg::*;

    logic              w_same;
    logic              w_hit;
    logic [ROT_W:0]    w_sum;

    // Same gate on the same first qubit
    assign w_same = i_top_valid && (i_gate == i_top_gate) && (i_qa == i_top_qa);

    // RZ merge: saturating add of the two angles
    assign w_sum = {i_top_rot[ROT_W-1], i_top_rot} + {i_rot[ROT_W-1], i_rot};
    assign o_merged_rot = (w_sum[ROT_W] != w_sum[ROT_W-1]) ?
                          {w_sum[ROT_W], {(ROT_W-1){~w_sum[ROT_W]}}} :
                          w_sum[ROT_W-1:0];

    // Peephole decision
    always_comb begin
        o_rule = '0;
        w_hit  = 1'b0;
        if (w_same) begin
            case (t_gate'(i_gate))
                GATE_H: begin
                    o_rule.pop = 1'b1;
                    w_hit      = 1'b1;
                end
                GATE_RZ: begin
                    o_rule.merge = 1'b1;
                    w_hit        = 1'b1;
                end
                GATE_CNOT, GATE_SWAP: begin
                    if (i_qb == i_top_qb) begin
                        o_rule.pop = 1'b1;
                        w_hit      = 1'b1;
                    end
                end
                default: begin
                    w_hit = 1'b0;
                end
            endcase
        end
        if (!w_hit) begin
            if (i_full) begin
                o_rule.drop = 1'b1;
            end else begin
                o_rule.push = 1'b1;
            end
        end
    end

endmodule

// ----- design/gate_stack_peephole_reducer.sv -----
// Channel   Handshake               Fields
// input     i_valid / o_stall       i_action i_gate_type i_qubit_a i_qubit_b
//                                   i_rotation i_read_index
// output    o_valid / i_stall       o_entry_count o_overflow_seen o_read_valid
//                                   o_read_gate o_read_qubit_a o_read_qubit_b
//                                   o_read_rotation
//
// Accepting an item issues the stack memory read (top entry, or the indexed
// entry for a read); the execute state then applies the rule and writes
// back, as the stack memory read is registered.
// Reset clears the depth count, the overflow flag and the control; the stack
// memory is not cleared, only entries below the depth are ever used.
// The result register frees the block to take the next item; only when a
// result is still waiting does a stall hold the item in the execute state.
module gate_stack_peephole_reducer #(
    parameter int STACK_DEPTH = gsp_pkg::STACK_DEPTH_DEF,
    parameter int QUBIT_BITS  = gsp_pkg::QUBIT_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_action,
    input  logic [gsp_pkg::GATE_W-1:0]            i_gate_type,
    input  logic [QUBIT_BITS-1:0]                 i_qubit_a,
    input  logic [QUBIT_BITS-1:0]                 i_qubit_b,
    input  logic signed [gsp_pkg::ROT_W-1:0]      i_rotation,
    input  logic [$clog2(STACK_DEPTH)-1:0]        i_read_index,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [$clog2(STACK_DEPTH+1)-1:0]      o_entry_count,
    output logic                                  o_overflow_seen,
    output logic                                  o_read_valid,
    output logic [gsp_pkg::GATE_W-1:0]            o_read_gate,
    output logic [QUBIT_BITS-1:0]                 o_read_qubit_a,
    output logic [QUBIT_BITS-1:0]                 o_read_qubit_b,
    output logic signed [gsp_pkg::ROT_W-1:0]      o_read_rotation
);

    import gsp_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int EW = GATE_W + 2 * QUBIT_BITS + ROT_W;

    // Control state
    t_state             r_state, n_state;
    logic [CW-1:0]      r_depth, n_depth;
    logic               r_overflow, n_overflow;
    logic               r_out_valid, n_out_valid;

    // Item held during execution
    logic                     r_action;
    logic [GATE_W-1:0]        r_gate;
    logic [QUBIT_BITS-1:0]    r_qa;
    logic [QUBIT_BITS-1:0]    r_qb;
    logic signed [ROT_W-1:0]  r_rot;
    logic [AW-1:0]            r_idx;

    // Result register
    logic [CW-1:0]            r_o_count;
    logic                     r_o_ovf;
    logic                     r_o_rvalid;
    logic [GATE_W-1:0]        r_o_gate;
    logic [QUBIT_BITS-1:0]    r_o_qa;
    logic [QUBIT_BITS-1:0]    r_o_qb;
    logic signed [ROT_W-1:0]  r_o_rot;

    logic                     w_accept;
    logic                     w_done;
    logic [CW-1:0]            w_depth_m1;
    logic [AW-1:0]            w_top_addr;
    logic [AW-1:0]            w_raddr;
    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic [EW-1:0]            w_wdata;
    logic [EW-1:0]            w_rdata;
    logic [GATE_W-1:0]        w_m_gate;
    logic [QUBIT_BITS-1:0]    w_m_qa;
    logic [QUBIT_BITS-1:0]    w_m_qb;
    logic signed [ROT_W-1:0]  w_m_rot;
    logic                     w_full;
    logic                     w_idx_ok;
    t_rule                    w_rule;
    logic signed [ROT_W-1:0]  w_merged_rot;

    assign w_depth_m1 = r_depth - CW'(1);
    assign w_top_addr = w_depth_m1[AW-1:0];
    assign w_full     = (r_depth == CW'(STACK_DEPTH));
    assign w_idx_ok   = (CW'(r_idx) < r_depth);
    assign w_raddr    = (i_action == ACT_READ) ? i_read_index : w_top_addr;

    assign {w_m_gate, w_m_qa, w_m_qb, w_m_rot} = w_rdata;

    // Stack memory
    gsp_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Rule evaluation against the fetched top
    gsp_rules #(
        .QUBIT_BITS (QUBIT_BITS)
    ) u_rules (
        .i_gate       (r_gate),
        .i_qa         (r_qa),
        .i_qb         (r_qb),
        .i_rot        (r_rot),
        .i_top_valid  (r_depth != '0),
        .i_top_gate   (w_m_gate),
        .i_top_qa     (w_m_qa),
        .i_top_qb     (w_m_qb),
        .i_top_rot    (w_m_rot),
        .i_full       (w_full),
        .o_rule       (w_rule),
        .o_merged_rot (w_merged_rot)
    );

    // Sequencer: next state and handshake
    always_comb begin
        n_state  = r_state;
        o_stall  = 1'b1;
        w_accept = 1'b0;
        w_done   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall  = 1'b0;
                w_accept = i_valid;
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                w_done = !r_out_valid || !i_stall;
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Depth, flag, write-back and result valid
    always_comb begin
        n_depth     = r_depth;
        n_overflow  = r_overflow;
        n_out_valid = r_out_valid;
        w_we        = 1'b0;
        w_waddr     = r_depth[AW-1:0];
        w_wdata     = {r_gate, r_qa, r_qb, r_rot};
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_done) begin
            n_out_valid = 1'b1;
            if (r_action == ACT_PUSH) begin
                if (w_rule.pop) begin
                    n_depth = w_depth_m1;
                end
                if (w_rule.merge) begin
                    w_we    = 1'b1;
                    w_waddr = w_top_addr;
                    w_wdata = {w_m_gate, w_m_qa, w_m_qb, w_merged_rot};
                end
                if (w_rule.push) begin
                    w_we    = 1'b1;
                    n_depth = r_depth + CW'(1);
                end
                if (w_rule.drop) begin
                    n_overflow = 1'b1;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_overflow  <= n_overflow;
            r_out_valid <= n_out_valid;
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_gate   <= i_gate_type;
            r_qa     <= i_qubit_a;
            r_qb     <= i_qubit_b;
            r_rot    <= i_rotation;
            r_idx    <= i_read_index;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_o_count <= n_depth;
            r_o_ovf   <= n_overflow;
            if ((r_action == ACT_READ) && w_idx_ok) begin
                r_o_rvalid <= 1'b1;
                r_o_gate   <= w_m_gate;
                r_o_qa     <= w_m_qa;
                r_o_qb     <= w_m_qb;
                r_o_rot    <= w_m_rot;
            end else begin
                r_o_rvalid <= 1'b0;
                r_o_gate   <= '0;
                r_o_qa     <= '0;
                r_o_qb     <= '0;
                r_o_rot    <= '0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_entry_count   = r_o_count;
    assign o_overflow_seen = r_o_ovf;
    assign o_read_valid    = r_o_rvalid;
    assign o_read_gate     = r_o_gate;
    assign o_read_qubit_a  = r_o_qa;
    assign o_read_qubit_b  = r_o_qb;
    assign o_read_rotation = r_o_rot;

endmodule
